/* sv/assert_macros.svh */
// Assertion macros shared by the sample clock setup RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define SSCS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sscs implication check failed");
`define SSCS_ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sscs invariant check failed");
`else
`define SSCS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define SSCS_ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`endif
`endif

/* sv/sscs_pkg.sv */
// Types, constants and format tables for the sample clock setup block.
package sscs_pkg;

    localparam int unsigned RATE_MIN_DEF = 1300000;
    localparam int unsigned RATE_MAX_DEF = 15000000;

    localparam int RATE_W = 25;
    localparam int PLL_W  = 24;
    localparam int PROD_W = 28;
    localparam int CAP_W  = 27;
    localparam int LIM_W  = 38;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_DECIM_MODE      = 3'd0,
        CFG_FORMAT_MODE     = 3'd1,
        CFG_FIXED_FORMAT    = 3'd2,
        CFG_SWAP_IQ         = 3'd3,
        CFG_BURST_COUNT     = 3'd4,
        CFG_BULK_TRANSFER   = 3'd5,
        CFG_BULK_CAPACITY   = 3'd6,
        CFG_DECIM_AUTO_RATE = 3'd7
    } t_cfg_idx;

    localparam logic [1:0] DECIM_OFF  = 2'd0;
    localparam logic [1:0] DECIM_ON   = 2'd1;
    localparam logic [1:0] DECIM_AUTO = 2'd2;

    localparam logic [1:0] FMODE_FIXED     = 2'd0;
    localparam logic [1:0] FMODE_AUTO_CPLX = 2'd1;
    localparam logic [1:0] FMODE_AUTO_REAL = 2'd2;

    localparam logic [2:0] FMT_252      = 3'd0;
    localparam logic [2:0] FMT_336      = 3'd1;
    localparam logic [2:0] FMT_384      = 3'd2;
    localparam logic [2:0] FMT_504      = 3'd3;
    localparam logic [2:0] FMT_504_S8   = 3'd4;
    localparam logic [2:0] FMT_504_REAL = 3'd5;
    localparam logic [2:0] FMT_672_REAL = 3'd6;
    localparam logic [2:0] FMT_768_REAL = 3'd7;

    localparam logic [1:0]        RST_DECIM_MODE   = DECIM_AUTO;
    localparam logic [1:0]        RST_FORMAT_MODE  = FMODE_AUTO_CPLX;
    localparam logic [2:0]        RST_FIXED_FORMAT = FMT_504;
    localparam logic [3:0]        RST_BURST_COUNT  = 4'd1;
    localparam logic [CAP_W-1:0]  RST_BULK_CAP     = 27'd24576000;
    localparam logic [RATE_W-1:0] RST_AUTO_RATE    = 25'd12096000;

    // bytes per second of one packet per burst at 8000 bursts/s
    localparam logic [CAP_W-1:0] CAP_UNIT = 27'd8192000;

    // samples per packet used by the fit checks, ascending
    localparam int unsigned FIT_SPP [6] = '{252, 336, 384, 504, 672, 768};

    // pll >= MULT_THR[i] means pll * (4 + 2i) * 12 reaches the VCO target
    localparam longint unsigned VCO_TARGET = 64'd202000000;
    localparam logic [PLL_W-1:0] MULT_THR [6] = '{
        24'((VCO_TARGET + 64'd47)  / 64'd48),
        24'((VCO_TARGET + 64'd71)  / 64'd72),
        24'((VCO_TARGET + 64'd95)  / 64'd96),
        24'((VCO_TARGET + 64'd119) / 64'd120),
        24'((VCO_TARGET + 64'd143) / 64'd144),
        24'((VCO_TARGET + 64'd167) / 64'd168)
    };
    localparam logic [3:0] MULT_LAST = 4'd14;
    localparam logic [2:0] CODE_NONE = 3'd7;

    // 4 MHz = 2^8 * REF_DIV; reciprocals for divide and fraction
    localparam logic [19:0] REF_DIV  = 20'd15625;
    localparam logic [20:0] N_RECIP  = 21'(((64'd1 << 34) + 64'd15624) / 64'd15625);
    localparam logic [35:0] FRAC_C   = 36'(((64'd1 << 49) + 64'd15624) / 64'd15625);
    localparam logic [17:0] FRAC_C_HI = FRAC_C[35:18];
    localparam logic [17:0] FRAC_C_LO = FRAC_C[17:0];

    typedef struct packed {
        logic [RATE_W-1:0] rate;
        logic              decim;
        logic [2:0]        fmt;
        logic              over;
        logic [2:0]        code;
    } t_side;

    function automatic logic [3:0] sat_burst(input logic [3:0] cnt);
        logic [3:0] res;
        res = cnt;
        if (cnt == 4'd0) res = 4'd1;
        else if (cnt > 4'd8) res = 4'd8;
        return res;
    endfunction

    function automatic logic [9:0] fmt_step(input logic [2:0] fmt);
        logic [9:0] res;
        unique case (fmt)
            FMT_252:      res = 10'd252;
            FMT_336:      res = 10'd336;
            FMT_384:      res = 10'd384;
            FMT_504:      res = 10'd504;
            FMT_504_S8:   res = 10'd504;
            FMT_504_REAL: res = 10'd504;
            FMT_672_REAL: res = 10'd672;
            FMT_768_REAL: res = 10'd768;
        endcase
        return res;
    endfunction

    function automatic logic [11:0] fmt_reg7(input logic [2:0] fmt);
        logic [11:0] res;
        unique case (fmt)
            FMT_252:      res = 12'h014;
            FMT_336:      res = 12'h005;
            FMT_384:      res = 12'h025;
            FMT_504:      res = 12'hc14;
            FMT_504_S8:   res = 12'hc14;
            FMT_504_REAL: res = 12'h414;
            FMT_672_REAL: res = 12'h405;
            FMT_768_REAL: res = 12'h425;
        endcase
        return res;
    endfunction

    function automatic logic [3:0] fmt_agc(input logic [2:0] fmt);
        logic [3:0] res;
        unique case (fmt)
            FMT_252:      res = 4'h1;
            FMT_336:      res = 4'h5;
            FMT_384:      res = 4'h9;
            FMT_504:      res = 4'hd;
            FMT_504_S8:   res = 4'hd;
            FMT_504_REAL: res = 4'h1;
            FMT_672_REAL: res = 4'h5;
            FMT_768_REAL: res = 4'h9;
        endcase
        return res;
    endfunction

endpackage

/* sv/sscs_clamp.sv */
// Stage 1: decimation bypass decision, rate clamp and PLL rate.
module sscs_clamp #(
    parameter int unsigned RATE_MIN = sscs_pkg::RATE_MIN_DEF,
    parameter int unsigned RATE_MAX = sscs_pkg::RATE_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [31:0]                   i_req,
    input  logic [1:0]                    i_decim_mode,
    input  logic [sscs_pkg::RATE_W-1:0]   i_auto_rate,
    output logic                          o_valid,
    output logic [sscs_pkg::RATE_W-1:0]   o_rate,
    output logic [sscs_pkg::PLL_W-1:0]    o_pll,
    output logic                          o_decim
);

    localparam logic [sscs_pkg::RATE_W-1:0] RMIN_LO = sscs_pkg::RATE_W'(RATE_MIN);
    localparam logic [sscs_pkg::RATE_W-1:0] RMIN_HI = sscs_pkg::RATE_W'(2 * RATE_MIN);
    localparam logic [sscs_pkg::RATE_W-1:0] RMAX_LO = sscs_pkg::RATE_W'(RATE_MAX);
    localparam logic [sscs_pkg::RATE_W-1:0] RMAX_HI = sscs_pkg::RATE_W'(2 * RATE_MAX);

    logic                        r_valid;
    logic [sscs_pkg::RATE_W-1:0] r_rate;
    logic [sscs_pkg::PLL_W-1:0]  r_pll;
    logic                        r_decim;

    logic                        n_decim;
    logic [sscs_pkg::RATE_W-1:0] rmin;
    logic [sscs_pkg::RATE_W-1:0] rmax;
    logic [sscs_pkg::RATE_W-1:0] n_rate;
    logic [sscs_pkg::PLL_W-1:0]  n_pll;

    always_comb begin
        n_decim = (i_decim_mode == sscs_pkg::DECIM_ON) ||
                  ((i_decim_mode == sscs_pkg::DECIM_AUTO) && (i_req > 32'(i_auto_rate)));
        rmin = n_decim ? RMIN_HI : RMIN_LO;
        rmax = n_decim ? RMAX_HI : RMAX_LO;
        if (i_req > 32'(rmax)) begin
            n_rate = rmax;
        end else if (i_req < 32'(rmin)) begin
            n_rate = rmin;
        end else begin
            n_rate = i_req[sscs_pkg::RATE_W-1:0];
        end
        n_pll = n_decim ? n_rate[sscs_pkg::RATE_W-1:1] : n_rate[sscs_pkg::PLL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rate  <= n_rate;
        r_pll   <= n_pll;
        r_decim <= n_decim;
    end

    assign o_valid = r_valid;
    assign o_rate  = r_rate;
    assign o_pll   = r_pll;
    assign o_decim = r_decim;

endmodule

/* sv/sscs_select.sv */
// Stage 2: packet format choice against link capacity and VCO multiplier pick.
module sscs_select (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [sscs_pkg::RATE_W-1:0]   i_rate,
    input  logic [sscs_pkg::PLL_W-1:0]    i_pll,
    input  logic                          i_decim,
    input  logic [1:0]                    i_format_mode,
    input  logic [2:0]                    i_fixed_format,
    input  logic [3:0]                    i_burst,
    input  logic                          i_bulk_transfer,
    input  logic [sscs_pkg::CAP_W-1:0]    i_bulk_capacity,
    output logic                          o_valid,
    output sscs_pkg::t_side               o_side,
    output logic [sscs_pkg::PROD_W-1:0]   o_prod
);

    logic                         r_valid;
    sscs_pkg::t_side              r_side;
    logic [sscs_pkg::PROD_W-1:0]  r_prod;
    logic [sscs_pkg::LIM_W-1:0]   r_lim [6];

    logic [sscs_pkg::CAP_W-1:0]   cap;
    logic [sscs_pkg::LIM_W-1:0]   n_lim [6];
    logic [sscs_pkg::LIM_W-1:0]   rate_scaled;
    logic [5:0]                   fit;
    sscs_pkg::t_side              n_side;
    logic [3:0]                   mult;
    logic [sscs_pkg::PROD_W-1:0]  n_prod;

    // fit limits are registered from the static configuration
    always_comb begin
        cap = i_bulk_transfer ? i_bulk_capacity
                              : sscs_pkg::CAP_W'(i_burst * sscs_pkg::CAP_UNIT);
        for (int i = 0; i < 6; i++) begin
            n_lim[i] = sscs_pkg::LIM_W'(cap) * sscs_pkg::LIM_W'(sscs_pkg::FIT_SPP[i])
                     + sscs_pkg::LIM_W'(sscs_pkg::FIT_SPP[i] - 1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_lim <= n_lim;
    end

    // rate*1024/spp <= cap  <=>  rate*1024 <= cap*spp + spp - 1
    always_comb begin
        rate_scaled = {3'b0, i_rate, 10'b0};
        for (int i = 0; i < 6; i++) begin
            fit[i] = (rate_scaled <= r_lim[i]);
        end
    end

    always_comb begin
        n_side       = '0;
        n_side.rate  = i_rate;
        n_side.decim = i_decim;
        unique case (i_format_mode)
            sscs_pkg::FMODE_FIXED: begin
                n_side.fmt  = i_fixed_format;
                n_side.over = 1'b0;
            end
            sscs_pkg::FMODE_AUTO_REAL: begin
                if (fit[3])      n_side.fmt = sscs_pkg::FMT_504_REAL;
                else if (fit[4]) n_side.fmt = sscs_pkg::FMT_672_REAL;
                else             n_side.fmt = sscs_pkg::FMT_768_REAL;
                n_side.over = !fit[5];
            end
            default: begin
                if (fit[0])      n_side.fmt = sscs_pkg::FMT_252;
                else if (fit[1]) n_side.fmt = sscs_pkg::FMT_336;
                else if (fit[2]) n_side.fmt = sscs_pkg::FMT_384;
                else             n_side.fmt = sscs_pkg::FMT_504;
                n_side.over = !fit[3];
            end
        endcase

        // first even multiplier from 4 up that reaches the VCO target
        mult        = sscs_pkg::MULT_LAST;
        n_side.code = sscs_pkg::CODE_NONE;
        for (int i = 5; i >= 0; i--) begin
            if (i_pll >= sscs_pkg::MULT_THR[i]) begin
                mult        = 4'(4 + 2 * i);
                n_side.code = 3'(i + 1);
            end
        end
        n_prod = sscs_pkg::PROD_W'(i_pll) * sscs_pkg::PROD_W'(mult);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side <= n_side;
        r_prod <= n_prod;
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_prod  = r_prod;

endmodule

/* sv/sscs_pll.sv */
// Stages 3 to 5: integer divider and 21-bit fraction of pll*mult over 4 MHz.
module sscs_pll (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  sscs_pkg::t_side               i_side,
    input  logic [sscs_pkg::PROD_W-1:0]   i_prod,
    output logic                          o_valid,
    output sscs_pkg::t_side               o_side,
    output logic [3:0]                    o_n,
    output logic [20:0]                   o_frac
);

    logic            r3_valid;
    sscs_pkg::t_side r3_side;
    logic [19:0]     r3_q1;
    logic [7:0]      r3_low8;
    logic [5:0]      r3_n;

    logic            r4_valid;
    sscs_pkg::t_side r4_side;
    logic [21:0]     r4_rem;
    logic [5:0]      r4_n;

    logic            r5_valid;
    sscs_pkg::t_side r5_side;
    logic [39:0]     r5_ph;
    logic [39:0]     r5_pl;
    logic [5:0]      r5_n;

    logic [40:0]     n_nprod;
    logic [19:0]     n_s;
    logic [39:0]     n_ph;
    logic [39:0]     n_pl;
    logic [57:0]     frac_sum;

    // quotient by reciprocal of the odd factor of 4 MHz
    assign n_nprod = {21'b0, i_prod[27:8]} * {20'b0, sscs_pkg::N_RECIP};
    assign n_s     = r3_q1 - 20'(r3_n) * sscs_pkg::REF_DIV;
    // frac = rem * 2^13 / 15625, constant split in two 18-bit halves
    assign n_ph    = 40'(r4_rem) * 40'(sscs_pkg::FRAC_C_HI);
    assign n_pl    = 40'(r4_rem) * 40'(sscs_pkg::FRAC_C_LO);
    assign frac_sum = {r5_ph, 18'b0} + 58'(r5_pl);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else begin
            r3_valid <= i_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_side <= i_side;
        r3_q1   <= i_prod[27:8];
        r3_low8 <= i_prod[7:0];
        r3_n    <= n_nprod[39:34];
        r4_side <= r3_side;
        r4_rem  <= {n_s[13:0], r3_low8};
        r4_n    <= r3_n;
        r5_side <= r4_side;
        r5_ph   <= n_ph;
        r5_pl   <= n_pl;
        r5_n    <= r4_n;
    end

    assign o_valid = r5_valid;
    assign o_side  = r5_side;
    assign o_n     = r5_n[3:0];
    assign o_frac  = frac_sum[56:36];

endmodule

/* sv/sdr_sample_clock_setup_top.sv */
// Top level of the sample clock setup block: config registers, pipeline, output packing.
// Takes one rate request per clock on i_start while o_busy is low and presents its result
// with o_valid after the transfer; o_valid lasts one cycle and cannot be held off.
// o_busy is high during reset and in the first cycle after it. A request passes the six
// register stages: clamp, format and VCO multiplier pick, reciprocal divide, remainder,
// fraction partial products and the output register. Configuration writes are registered
// and belong in idle periods.
module sdr_sample_clock_setup_top #(
    parameter int unsigned RATE_MIN = sscs_pkg::RATE_MIN_DEF,
    parameter int unsigned RATE_MAX = sscs_pkg::RATE_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [31:0]                   i_requested_rate,
    input  logic                          i_cfg_we,
    input  logic [2:0]                    i_cfg_addr,
    input  logic [sscs_pkg::CAP_W-1:0]    i_cfg_data,
    output logic                          o_valid,
    output logic [sscs_pkg::RATE_W-1:0]   o_clamped_rate,
    output logic [2:0]                    o_chosen_format,
    output logic [9:0]                    o_frame_step,
    output logic [3:0]                    o_divider_int,
    output logic [20:0]                   o_divider_frac,
    output logic [16:0]                   o_reg3_word,
    output logic [19:0]                   o_reg4_word,
    output logic [11:0]                   o_reg7_word,
    output logic                          o_over_capacity
);

`include "assert_macros.svh"

    logic                        r_busy;
    logic [1:0]                  r_decim_mode;
    logic [1:0]                  r_format_mode;
    logic [2:0]                  r_fixed_format;
    logic                        r_swap_iq;
    logic [3:0]                  r_burst_count;
    logic                        r_bulk_transfer;
    logic [sscs_pkg::CAP_W-1:0]  r_bulk_capacity;
    logic [sscs_pkg::RATE_W-1:0] r_auto_rate;

    logic                        r_valid;
    logic [sscs_pkg::RATE_W-1:0] r_clamped_rate;
    logic [2:0]                  r_chosen_format;
    logic [9:0]                  r_frame_step;
    logic [3:0]                  r_divider_int;
    logic [20:0]                 r_divider_frac;
    logic [16:0]                 r_reg3_word;
    logic [19:0]                 r_reg4_word;
    logic [11:0]                 r_reg7_word;
    logic                        r_over_capacity;

    logic                        w_accept;
    logic [3:0]                  burst;

    logic                        s1_valid;
    logic [sscs_pkg::RATE_W-1:0] s1_rate;
    logic [sscs_pkg::PLL_W-1:0]  s1_pll;
    logic                        s1_decim;

    logic                        s2_valid;
    sscs_pkg::t_side             s2_side;
    logic [sscs_pkg::PROD_W-1:0] s2_prod;

    logic                        s5_valid;
    sscs_pkg::t_side             s5_side;
    logic [3:0]                  s5_n;
    logic [20:0]                 s5_frac;

    logic                        real_fmt;
    logic [2:0]                  burst_m1;
    logic [16:0]                 n_reg3;
    logic [11:0]                 n_reg7;

    assign w_accept = i_start && !r_busy;
    assign burst    = sscs_pkg::sat_burst(r_burst_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy          <= 1'b1;
            r_decim_mode    <= sscs_pkg::RST_DECIM_MODE;
            r_format_mode   <= sscs_pkg::RST_FORMAT_MODE;
            r_fixed_format  <= sscs_pkg::RST_FIXED_FORMAT;
            r_swap_iq       <= 1'b0;
            r_burst_count   <= sscs_pkg::RST_BURST_COUNT;
            r_bulk_transfer <= 1'b0;
            r_bulk_capacity <= sscs_pkg::RST_BULK_CAP;
            r_auto_rate     <= sscs_pkg::RST_AUTO_RATE;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_we) begin
                unique case (sscs_pkg::t_cfg_idx'(i_cfg_addr))
                    sscs_pkg::CFG_DECIM_MODE:      r_decim_mode    <= i_cfg_data[1:0];
                    sscs_pkg::CFG_FORMAT_MODE:     r_format_mode   <= i_cfg_data[1:0];
                    sscs_pkg::CFG_FIXED_FORMAT:    r_fixed_format  <= i_cfg_data[2:0];
                    sscs_pkg::CFG_SWAP_IQ:         r_swap_iq       <= i_cfg_data[0];
                    sscs_pkg::CFG_BURST_COUNT:     r_burst_count   <= i_cfg_data[3:0];
                    sscs_pkg::CFG_BULK_TRANSFER:   r_bulk_transfer <= i_cfg_data[0];
                    sscs_pkg::CFG_BULK_CAPACITY:   r_bulk_capacity <= i_cfg_data;
                    sscs_pkg::CFG_DECIM_AUTO_RATE:
                        r_auto_rate <= i_cfg_data[sscs_pkg::RATE_W-1:0];
                endcase
            end
        end
    end

    sscs_clamp #(
        .RATE_MIN (RATE_MIN),
        .RATE_MAX (RATE_MAX)
    ) u_clamp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_accept),
        .i_req        (i_requested_rate),
        .i_decim_mode (r_decim_mode),
        .i_auto_rate  (r_auto_rate),
        .o_valid      (s1_valid),
        .o_rate       (s1_rate),
        .o_pll        (s1_pll),
        .o_decim      (s1_decim)
    );

    sscs_select u_select (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (s1_valid),
        .i_rate          (s1_rate),
        .i_pll           (s1_pll),
        .i_decim         (s1_decim),
        .i_format_mode   (r_format_mode),
        .i_fixed_format  (r_fixed_format),
        .i_burst         (burst),
        .i_bulk_transfer (r_bulk_transfer),
        .i_bulk_capacity (r_bulk_capacity),
        .o_valid         (s2_valid),
        .o_side          (s2_side),
        .o_prod          (s2_prod)
    );

    sscs_pll u_pll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .i_side  (s2_side),
        .i_prod  (s2_prod),
        .o_valid (s5_valid),
        .o_side  (s5_side),
        .o_n     (s5_n),
        .o_frac  (s5_frac)
    );

    always_comb begin
        real_fmt = (s5_side.fmt >= sscs_pkg::FMT_504_REAL);
        burst_m1 = 3'(burst - 4'd1);
        n_reg3   = {1'b1, sscs_pkg::fmt_agc(s5_side.fmt), s5_n, s5_frac[20],
                    real_fmt && !r_swap_iq, real_fmt && r_swap_iq, s5_side.code, 2'b11};
        n_reg7   = sscs_pkg::fmt_reg7(s5_side.fmt)
                 | {2'b0, r_swap_iq, burst_m1, 2'b0, s5_side.decim, 3'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= s5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_clamped_rate  <= s5_side.rate;
        r_chosen_format <= s5_side.fmt;
        r_frame_step    <= sscs_pkg::fmt_step(s5_side.fmt);
        r_divider_int   <= s5_n;
        r_divider_frac  <= s5_frac;
        r_reg3_word     <= n_reg3;
        r_reg4_word     <= s5_frac[19:0];
        r_reg7_word     <= n_reg7;
        r_over_capacity <= s5_side.over;
    end

    assign o_busy          = r_busy;
    assign o_valid         = r_valid;
    assign o_clamped_rate  = r_clamped_rate;
    assign o_chosen_format = r_chosen_format;
    assign o_frame_step    = r_frame_step;
    assign o_divider_int   = r_divider_int;
    assign o_divider_frac  = r_divider_frac;
    assign o_reg3_word     = r_reg3_word;
    assign o_reg4_word     = r_reg4_word;
    assign o_reg7_word     = r_reg7_word;
    assign o_over_capacity = r_over_capacity;

    // a result appears only for a transfer that was accepted
    `SSCS_ASSERT_IMPL(a_latency, i_clk, i_rst_n, r_valid, $past(w_accept, 6))
    // results without bypass stay within the base range
    `SSCS_ASSERT_IMPL(a_base_range, i_clk, i_rst_n, r_valid && !r_reg7_word[3],
        (r_clamped_rate >= sscs_pkg::RATE_W'(RATE_MIN)) &&
        (r_clamped_rate <= sscs_pkg::RATE_W'(RATE_MAX)))
    // fixed format never reports a capacity overrun
    `SSCS_ASSERT_IMPL(a_fixed_over, i_clk, i_rst_n,
        r_valid && (r_format_mode == sscs_pkg::FMODE_FIXED), !r_over_capacity)
    // integer divider and fraction fields agree with the packed words
    `SSCS_ASSERT_IMPL(a_pack, i_clk, i_rst_n, r_valid,
        (r_reg3_word[11:8] == r_divider_int) && (r_reg3_word[7] == r_divider_frac[20]))

endmodule
